@@ hdl/ght_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

  // Fixed widths of the handle fields on the channels.
  localparam int HIDX_W = 6;
  localparam int HGEN_W = 8;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_STALE = 3'd3,
    ST_DEAD  = 3'd4,
    ST_FULL  = 3'd5,
    ST_ARGS  = 3'd6
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0] handle_gen;
    logic              handle_valid;
    logic              create_args_ok;
  } ght_req_t;

  typedef struct packed {
    logic              ok;
    status_t           status;
    logic [HIDX_W-1:0] result_index;
    logic [HGEN_W-1:0] result_gen;
  } ght_rsp_t;

endpackage

`default_nettype wire

@@ hdl/ght_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ght_req_if;
  import ght_pkg::*;

  logic     valid;
  logic     ready;
  ght_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/ght_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ght_rsp_if;
  import ght_pkg::*;

  logic     valid;
  logic     ready;
  ght_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/ght_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read at the written
  // address returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/generational_handle_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An accepted word waits in stage one until the output register is free or draining;
// its result is then registered there. One word per cycle while the result side is ready;
// the slot memory and the free stack each see one read and one write per cycle, with a
// one-deep bypass for back-to-back hazards. Reset clears the used and free counts and the
// pipeline valid bits; memories are not swept: entries at or above the counts are unused.
module generational_handle_table_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_WIDTH  = 8
) (
  input wire logic clk,
  input wire logic rst,
  ght_req_if.sink  req,
  ght_rsp_if.source rsp
);
  import ght_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W  = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
  localparam int GCMP_W = (GEN_WIDTH > HGEN_W) ? GEN_WIDTH : HGEN_W;
  localparam int SLOT_W = GEN_WIDTH + 1;
  localparam int STK_W  = IDX_W + GEN_WIDTH;
  localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOT_COUNT);

  // Pipeline and table state.
  logic              s1_valid;
  ght_req_t          s1_req;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  used_count;
  logic              slot_byp;
  logic [SLOT_W-1:0] slot_byp_data;
  logic              stk_byp;
  logic [STK_W-1:0]  stk_byp_data;
  logic              out_valid;
  ght_rsp_t          out_data;

  // Handshake and memory signals.
  logic              accept;
  logic              s1_retire;
  logic [SLOT_W-1:0] slot_rdata;
  logic [SLOT_W-1:0] slot_rd;
  logic [STK_W-1:0]  stk_rdata;
  logic [STK_W-1:0]  stk_rd;
  logic [IDX_W-1:0]  slot_raddr;
  logic [IDX_W-1:0]  stk_raddr;
  logic [CNT_W-1:0]  stk_top;
  logic [CMP_W-1:0]  in_idx_ext;

  // Processing results of the word in stage one.
  logic [CMP_W-1:0]     idx_ext;
  logic [IDX_W-1:0]     idx;
  logic [GEN_WIDTH-1:0] cur_gen;
  logic                 cur_alive;
  status_t              chk_status;
  status_t              res_status;
  logic [IDX_W-1:0]     res_idx;
  logic [GEN_WIDTH-1:0] res_gen;
  logic [CNT_W-1:0]     free_upd;
  logic [CNT_W-1:0]     used_upd;
  logic [CNT_W-1:0]     free_count_next;
  logic                 slot_we_op;
  logic [IDX_W-1:0]     slot_waddr;
  logic [SLOT_W-1:0]    slot_wdata;
  logic                 stk_we_op;
  logic [IDX_W-1:0]     stk_waddr;
  logic [STK_W-1:0]     stk_wdata;
  logic                 slot_we;
  logic                 stk_we;
  logic [CMP_W-1:0]     res_idx_ext;
  logic [GCMP_W-1:0]    res_gen_ext;

  // Handshakes: stage one moves on whenever the output register is free or being drained.
  assign s1_retire = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_retire;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Memory read data, with the word written in the same edge forwarded.
  assign slot_rd = slot_byp ? slot_byp_data : slot_rdata;
  assign stk_rd  = stk_byp ? stk_byp_data : stk_rdata;

  // Handle checks in priority order: empty, range, generation, alive.
  assign idx_ext   = CMP_W'(s1_req.handle_index);
  assign idx       = idx_ext[IDX_W-1:0];
  assign cur_gen   = slot_rd[SLOT_W-1:1];
  assign cur_alive = slot_rd[0];

  always_comb begin
    if (!s1_req.handle_valid) begin
      chk_status = ST_EMPTY;
    end else if (idx_ext >= CMP_W'(used_count)) begin
      chk_status = ST_RANGE;
    end else if (GCMP_W'(s1_req.handle_gen) != GCMP_W'(cur_gen)) begin
      chk_status = ST_STALE;
    end else if (!cur_alive) begin
      chk_status = ST_DEAD;
    end else begin
      chk_status = ST_OK;
    end
  end

  // Operation decode. The slot memory holds {generation, alive}; the free stack holds
  // {index, generation}, so a pop yields the slot's generation without a second read.
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_gen    = '0;
    free_upd   = free_count;
    used_upd   = used_count;
    slot_we_op = 1'b0;
    slot_waddr = idx;
    slot_wdata = {GEN_WIDTH'(cur_gen + GEN_WIDTH'(1)), 1'b0};
    stk_we_op  = 1'b0;
    stk_waddr  = free_count[IDX_W-1:0];
    stk_wdata  = {idx, GEN_WIDTH'(cur_gen + GEN_WIDTH'(1))};
    case (s1_req.op)
      OP_CREATE: begin
        if (!s1_req.create_args_ok) begin
          res_status = ST_ARGS;
        end else if (free_count != '0) begin
          free_upd   = free_count - CNT_W'(1);
          res_idx    = stk_rd[STK_W-1:GEN_WIDTH];
          res_gen    = stk_rd[GEN_WIDTH-1:0];
          slot_we_op = 1'b1;
          slot_waddr = stk_rd[STK_W-1:GEN_WIDTH];
          slot_wdata = {stk_rd[GEN_WIDTH-1:0], 1'b1};
        end else if (used_count != SLOT_MAX) begin
          used_upd   = used_count + CNT_W'(1);
          res_idx    = used_count[IDX_W-1:0];
          slot_we_op = 1'b1;
          slot_waddr = used_count[IDX_W-1:0];
          slot_wdata = {{GEN_WIDTH{1'b0}}, 1'b1};
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        res_status = chk_status;
        if (chk_status == ST_OK) begin
          res_idx    = idx;
          res_gen    = cur_gen;
          slot_we_op = 1'b1;
          if (free_count != SLOT_MAX) begin
            stk_we_op = 1'b1;
            free_upd  = free_count + CNT_W'(1);
          end
        end
      end
      OP_LOOKUP: begin
        res_status = chk_status;
        if (chk_status == ST_OK) begin
          res_idx = idx;
          res_gen = cur_gen;
        end
      end
      OP_CLEAR: begin
        free_upd = '0;
        used_upd = '0;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Writes and count updates take effect only when the word leaves stage one.
  assign slot_we         = s1_retire && slot_we_op;
  assign stk_we          = s1_retire && stk_we_op;
  assign free_count_next = s1_retire ? free_upd : free_count;

  // Read addresses for the incoming word, using the counts as they stand after this edge.
  assign in_idx_ext = CMP_W'(req.data.handle_index);
  assign slot_raddr = in_idx_ext[IDX_W-1:0];
  assign stk_top    = free_count_next - CNT_W'(1);
  assign stk_raddr  = stk_top[IDX_W-1:0];

  assign res_idx_ext = CMP_W'(res_idx);
  assign res_gen_ext = GCMP_W'(res_gen);

  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ght_ram #(
    .WIDTH (STK_W),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Control state: pipeline valid bits and the two counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      free_count <= '0;
      used_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_retire) begin
        s1_valid <= 1'b0;
      end
      if (s1_retire) begin
        out_valid  <= 1'b1;
        free_count <= free_upd;
        used_count <= used_upd;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted word, its bypass captures, and the result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req        <= req.data;
      slot_byp      <= slot_we && (slot_waddr == slot_raddr);
      slot_byp_data <= slot_wdata;
      stk_byp       <= stk_we && (stk_waddr == stk_raddr);
      stk_byp_data  <= stk_wdata;
    end
    if (s1_retire) begin
      out_data.ok           <= (res_status == ST_OK);
      out_data.status       <= res_status;
      out_data.result_index <= res_idx_ext[HIDX_W-1:0];
      out_data.result_gen   <= res_gen_ext[HGEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ tb/ght_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the handle table and checks every
// result word against the oldest prediction.
module ght_checker #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_WIDTH  = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ght_req_if          req,
  ght_rsp_if          rsp,
  output int unsigned fail_count,
  output int unsigned pending
);
  import ght_pkg::*;

  // Shadow copy of the table state.
  logic [GEN_WIDTH-1:0] slot_gen  [SLOT_COUNT];
  logic                 slot_live [SLOT_COUNT];
  int unsigned          freed     [SLOT_COUNT];
  int unsigned          freed_top;
  int unsigned          high_water;

  // Results still owed by the block, oldest first.
  ght_rsp_t             owed_results [$];

  task automatic report_mismatch(string msg);
    $display("%0t ght_checker: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_gen[i]  = '0;
      slot_live[i] = 1'b0;
    end
    freed_top  = 0;
    high_water = 0;
  endfunction

  function automatic ght_rsp_t make_result(status_t st, int unsigned idx, int unsigned gen);
    ght_rsp_t r;
    r.ok           = (st == ST_OK);
    r.status       = st;
    r.result_index = HIDX_W'(idx);
    r.result_gen   = HGEN_W'(gen);
    return r;
  endfunction

  // Handle checks run as valid mark, range, generation, alive; the first miss wins.
  function automatic status_t handle_status(ght_req_t w);
    int unsigned idx;
    idx = w.handle_index;
    if (!w.handle_valid) begin
      return ST_EMPTY;
    end else if (idx >= high_water || idx >= SLOT_COUNT) begin
      return ST_RANGE;
    end else if (int'(w.handle_gen) != int'(slot_gen[idx])) begin
      return ST_STALE;
    end else if (!slot_live[idx]) begin
      return ST_DEAD;
    end
    return ST_OK;
  endfunction

  // Applies one request word to the shadow table and returns the result it should give.
  function automatic ght_rsp_t table_apply(ght_req_t w);
    int unsigned slot;
    status_t     st;
    ght_rsp_t    r;
    case (w.op)
      OP_CREATE: begin
        if (!w.create_args_ok) begin
          r = make_result(ST_ARGS, 0, 0);
        end else if (freed_top > 0) begin
          // Most recently freed slot comes back first.
          freed_top--;
          slot = freed[freed_top];
          slot_live[slot] = 1'b1;
          r = make_result(ST_OK, slot, slot_gen[slot]);
        end else if (high_water < SLOT_COUNT) begin
          slot = high_water;
          high_water++;
          slot_gen[slot]  = '0;
          slot_live[slot] = 1'b1;
          r = make_result(ST_OK, slot, slot_gen[slot]);
        end else begin
          r = make_result(ST_FULL, 0, 0);
        end
      end
      OP_DESTROY: begin
        st = handle_status(w);
        if (st != ST_OK) begin
          r = make_result(st, 0, 0);
        end else begin
          // The result carries the generation from before the bump.
          slot = w.handle_index;
          r = make_result(ST_OK, slot, slot_gen[slot]);
          slot_gen[slot]  = slot_gen[slot] + 1'b1;
          slot_live[slot] = 1'b0;
          if (freed_top < SLOT_COUNT) begin
            freed[freed_top] = slot;
            freed_top++;
          end
        end
      end
      OP_LOOKUP: begin
        st = handle_status(w);
        if (st != ST_OK) begin
          r = make_result(st, 0, 0);
        end else begin
          r = make_result(ST_OK, w.handle_index, slot_gen[w.handle_index]);
        end
      end
      default: begin
        clear_table();
        r = make_result(ST_OK, 0, 0);
      end
    endcase
    return r;
  endfunction

  // Compare finished words first, then record the prediction for a newly accepted word.
  always @(posedge clk) begin
    ght_rsp_t want;
    if (rst) begin
      clear_table();
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = owed_results.pop_front();
          if (rsp.data.ok !== want.ok) begin
            report_mismatch($sformatf("ok: got %0b expected %0b", rsp.data.ok, want.ok));
          end
          if (rsp.data.status !== want.status) begin
            report_mismatch($sformatf("status: got %0d expected %0d",
                                      rsp.data.status, want.status));
          end
          if (rsp.data.result_index !== want.result_index) begin
            report_mismatch($sformatf("result_index: got %0d expected %0d",
                                      rsp.data.result_index, want.result_index));
          end
          if (rsp.data.result_gen !== want.result_gen) begin
            report_mismatch($sformatf("result_gen: got %0d expected %0d",
                                      rsp.data.result_gen, want.result_gen));
          end
        end
      end
      if (req.valid && req.ready) begin
        owed_results = {owed_results, table_apply(req.data)};
      end
    end
    pending <= owed_results.size();
  end

endmodule

@@ tb/tb_generational_handle_table_unit.sv @@
`timescale 1ns / 1ps

module tb_generational_handle_table_unit;
  import ght_pkg::*;

  localparam int SLOTS = 64;

  typedef struct {
    logic [HIDX_W-1:0] idx;
    logic [HGEN_W-1:0] gen;
  } handle_t;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        quiet = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_left = 0;

  // Ops in flight, and handles seen in results for reuse by later requests.
  op_t         sent_ops    [$];
  handle_t     handle_pool [$];

  ght_req_if req ();
  ght_rsp_if rsp ();

  generational_handle_table_unit #(
    .SLOT_COUNT(SLOTS),
    .GEN_WIDTH (8)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  ght_checker #(
    .SLOT_COUNT(SLOTS),
    .GEN_WIDTH (8)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_generational_handle_table_unit: done, errors");
    $finish;
  end

  // Result side stalls at random unless the run is in a quiet stretch.
  always @(negedge clk) begin
    if (quiet || rst) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      rsp.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Collect live-looking handles from results so destroy and lookup hit real slots.
  always @(posedge clk) begin
    handle_t h;
    op_t     op;
    if (!rst && rsp.valid && rsp.ready && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (op == OP_CLEAR) begin
        handle_pool.delete();
      end else if (rsp.data.ok) begin
        h.idx = rsp.data.result_index;
        h.gen = rsp.data.result_gen + HGEN_W'(op == OP_DESTROY);
        handle_pool = {handle_pool, h};
        if (handle_pool.size() > 48) begin
          void'(handle_pool.pop_front());
        end
      end
    end
  end

  function automatic ght_req_t make_word(op_t op, logic [HIDX_W-1:0] idx,
                                         logic [HGEN_W-1:0] gen, logic hv, logic args);
    ght_req_t w;
    w.op             = op;
    w.handle_index   = idx;
    w.handle_gen     = gen;
    w.handle_valid   = hv;
    w.create_args_ok = args;
    return w;
  endfunction

  // Mostly handles taken from earlier results, sometimes nudged or fully random.
  function automatic ght_req_t random_word();
    ght_req_t    w;
    handle_t     h;
    int unsigned pick;
    w = make_word(OP_CREATE, HIDX_W'($urandom), HGEN_W'($urandom),
                  $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.op = OP_CREATE;
    end else if (pick < 68) begin
      w.op = OP_DESTROY;
    end else if (pick < 98) begin
      w.op = OP_LOOKUP;
    end else begin
      w.op = OP_CLEAR;
    end
    if ((w.op == OP_DESTROY || w.op == OP_LOOKUP) && handle_pool.size() > 0 &&
        $urandom_range(0, 3) != 0) begin
      h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
      w.handle_index = h.idx;
      w.handle_gen   = ($urandom_range(0, 7) == 0) ? h.gen + 1'b1 : h.gen;
      w.handle_valid = 1'b1;
    end
    return w;
  endfunction

  // Drives one word from a falling edge and holds it until the block takes it.
  task automatic send_word(ght_req_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req.data  <= w;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    sent_ops = {sent_ops, w.op};
    @(negedge clk);
  endtask

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every status code but full, LIFO reuse and clear.
    send_word(make_word(OP_LOOKUP, '1, '1, 1'b0, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, '1, '1, 1'b1, 1'b0));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b0, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd0, 1'b1, 1'b0));
    send_word(make_word(OP_LOOKUP, 6'd1, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd1, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, '1, '1, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd2, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd1, 1'b1, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd0, 8'd1, 1'b1, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd1, 8'd0, 1'b0, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd1, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, '1, '1, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b0, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CLEAR, '1, '1, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b0, 1'b0));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b1, 1'b1));

    // Fill the table past capacity, then free and refill the top slot.
    send_word(make_word(OP_CLEAR, 6'd0, 8'd0, 1'b0, 1'b0));
    repeat (66) begin
      send_word(make_word(OP_CREATE, HIDX_W'($urandom), HGEN_W'($urandom),
                          1'($urandom), 1'b1));
    end
    send_word(make_word(OP_LOOKUP, 6'd63, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_DESTROY, 6'd63, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_CREATE, 6'd0, 8'd0, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd63, 8'd1, 1'b1, 1'b1));

    // Let the block drain completely before the churn phase.
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Churn one slot through a full generation wrap.
    quiet <= 1'b1;
    send_word(make_word(OP_CLEAR, 6'd0, 8'd0, 1'b1, 1'b1));
    for (int g = 0; g <= 256; g++) begin
      if (g == 128) begin
        quiet <= 1'b0;
      end
      send_word(make_word(OP_CREATE, HIDX_W'($urandom), HGEN_W'($urandom), 1'b1, 1'b1));
      send_word(make_word(OP_DESTROY, 6'd0, HGEN_W'(g), 1'b1, 1'b1));
    end
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd1, 1'b1, 1'b1));
    send_word(make_word(OP_LOOKUP, 6'd0, 8'd255, 1'b1, 1'b1));

    // Random mix; the tail runs with no idling on either side.
    for (int n = 0; n < 560; n++) begin
      if (n == 410) begin
        quiet <= 1'b1;
      end
      send_word(random_word());
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_generational_handle_table_unit: done, clean");
    end else begin
      $display("tb_generational_handle_table_unit: done, errors");
    end
    $finish;
  end

endmodule
